// ===== rtl/lspe_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lspe_pkg;

  localparam int SENSOR_COUNT = 5;
  localparam int CENTRE_SENSOR = 2;
  localparam int RAW_W = 10;
  localparam int OFS_W = RAW_W + 1;
  localparam int THR_W = 10;
  localparam int GAIN_W = 8;
  localparam int ERR_W = 7;
  localparam int DRIVE_W = 15;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [THR_W-1:0] THRESHOLD_RST = THR_W'(600);
  localparam logic [GAIN_W-1:0] KP_GAIN_RST = GAIN_W'(12);

  localparam logic signed [ERR_W-1:0] W_EDGE = ERR_W'(50);
  localparam logic signed [ERR_W-1:0] W_OUTER_PAIR = ERR_W'(30);
  localparam logic signed [ERR_W-1:0] W_INNER = ERR_W'(22);
  localparam logic signed [ERR_W-1:0] W_INNER_PAIR = ERR_W'(17);

  typedef enum logic [1:0] {
    REG_THRESHOLD  = 2'd0,
    REG_LIGHT_LINE = 2'd1,
    REG_KP_GAIN    = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [THR_W-1:0] threshold;
    logic             light_line;
  } cmp_cfg_t;

  typedef struct packed {
    logic accept;
    logic calibrate;
  } lane_ctl_t;

  // weight for a line under one sensor or two neighbors, else zero
  function automatic logic signed [ERR_W-1:0] pattern_weight(
    input logic [SENSOR_COUNT-1:0] pattern
  );
    logic signed [ERR_W-1:0] w;
    case (pattern)
      5'b00001: w = -W_EDGE;
      5'b00011: w = -W_OUTER_PAIR;
      5'b00010: w = -W_INNER;
      5'b00110: w = -W_INNER_PAIR;
      5'b01100: w = W_INNER_PAIR;
      5'b01000: w = W_INNER;
      5'b11000: w = W_OUTER_PAIR;
      5'b10000: w = W_EDGE;
      default:  w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/lspe_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lspe_req_if import lspe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             req_type;
  logic [RAW_W-1:0] raw0;
  logic [RAW_W-1:0] raw1;
  logic [RAW_W-1:0] raw2;
  logic [RAW_W-1:0] raw3;
  logic [RAW_W-1:0] raw4;

  modport source (output valid, req_type, raw0, raw1, raw2, raw3, raw4, input ready);
  modport sink (input valid, req_type, raw0, raw1, raw2, raw3, raw4, output ready);
endinterface

`default_nettype wire

// ===== rtl/lspe_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface lspe_rsp_if import lspe_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [SENSOR_COUNT-1:0]   status_bits;
  logic signed [ERR_W-1:0]   position_error;
  logic signed [DRIVE_W-1:0] drive;

  modport source (output valid, status_bits, position_error, drive, input ready);
  modport sink (input valid, status_bits, position_error, drive, output ready);
endinterface

`default_nettype wire

// ===== rtl/lspe_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lspe_lane import lspe_pkg::*; (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [RAW_W-1:0] raw,
  input  wire logic [RAW_W-1:0] centre,
  input  wire lane_ctl_t        ctl,
  input  wire cmp_cfg_t         cfg,
  output logic                  hit
);

  logic signed [OFS_W-1:0] offset;
  logic signed [OFS_W-1:0] offset_next;
  logic signed [OFS_W:0]   sum;
  logic signed [OFS_W:0]   thr;

  assign offset_next = $signed({1'b0, centre}) - $signed({1'b0, raw});
  assign sum = $signed({2'b00, raw}) + $signed({offset[OFS_W-1], offset});
  assign thr = $signed({2'b00, cfg.threshold});

  // equal to threshold never flags
  always_comb begin
    if (cfg.light_line) begin
      hit = sum > thr;
    end else begin
      hit = sum < thr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (ctl.accept && ctl.calibrate) begin
      offset <= offset_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/lspe_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lspe_merge import lspe_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_calib,
  input  wire logic [SENSOR_COUNT-1:0] in_flags,
  input  wire logic [GAIN_W-1:0]       kp_gain,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic [SENSOR_COUNT-1:0]      status_bits,
  output logic signed [ERR_W-1:0]      position_error,
  output logic signed [DRIVE_W-1:0]    drive
);

  localparam int PROD_W = GAIN_W + 1 + ERR_W;

  logic signed [ERR_W-1:0]  err;
  logic signed [PROD_W-1:0] prod;
  logic                     load;

  assign err = pattern_weight(in_flags);
  assign prod = $signed({1'b0, kp_gain}) * err;
  assign in_ready = !out_valid || out_ready;
  assign load = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      if (in_calib) begin
        status_bits    <= '0;
        position_error <= '0;
        drive          <= '0;
      end else begin
        status_bits    <= in_flags;
        position_error <= err;
        drive          <= prod[DRIVE_W-1:0];
      end
    end
  end

  a_zero_err_zero_drive: assert property (@(posedge clk) disable iff (rst)
    out_valid && position_error == '0 |-> drive == '0)
    else $error("drive nonzero with zero position error");

  a_calib_zero: assert property (@(posedge clk) disable iff (rst)
    load && in_calib |=> status_bits == '0 && position_error == '0 && drive == '0)
    else $error("calibrate result not all zero");

  a_flags_kept: assert property (@(posedge clk) disable iff (rst)
    load && !in_calib |=> status_bits == $past(in_flags))
    else $error("status bits differ from lane flags");

  a_no_line_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && status_bits == '0 |-> position_error == '0)
    else $error("position error without any flag");

endmodule

`default_nettype wire

// ===== rtl/line_sensor_position_error_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// a request's result is registered first in the flag stage and then in the merge output register
// throughput: one request per cycle while rsp.ready holds, set by the five compare lanes working
//   in parallel and a single registered table lookup and gain multiply
// reset (rst, synchronous): pipeline emptied, offsets cleared to zero,
//   threshold 600, light_line 0, kp_gain 12
module line_sensor_position_error_core import lspe_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  lspe_req_if.sink               req,
  lspe_rsp_if.source             rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [ADDR_W-1:0] paddr,
  input  wire logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0]      prdata,
  output logic                   pready
);

  logic [THR_W-1:0]  threshold;
  logic              light_line;
  logic [GAIN_W-1:0] kp_gain;
  logic              cfg_write;
  reg_idx_t          reg_idx;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign reg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold  <= THRESHOLD_RST;
      light_line <= 1'b0;
      kp_gain    <= KP_GAIN_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_THRESHOLD:  threshold <= pwdata[THR_W-1:0];
        REG_LIGHT_LINE: light_line <= pwdata[0];
        REG_KP_GAIN:    kp_gain <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_THRESHOLD:  prdata = DATA_W'(threshold);
      REG_LIGHT_LINE: prdata = DATA_W'(light_line);
      REG_KP_GAIN:    prdata = DATA_W'(kp_gain);
      default:        prdata = '0;
    endcase
  end

  logic [RAW_W-1:0]        raw [SENSOR_COUNT];
  logic [SENSOR_COUNT-1:0] hits;
  lane_ctl_t               ctl;
  cmp_cfg_t                cmp_cfg;
  logic                    accept;

  assign raw[0] = req.raw0;
  assign raw[1] = req.raw1;
  assign raw[2] = req.raw2;
  assign raw[3] = req.raw3;
  assign raw[4] = req.raw4;

  assign accept = req.valid && req.ready;
  assign ctl.accept = accept;
  assign ctl.calibrate = req.req_type;
  assign cmp_cfg.threshold = threshold;
  assign cmp_cfg.light_line = light_line;

  for (genvar i = 0; i < SENSOR_COUNT; i++) begin : g_lane
    lspe_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .raw    (raw[i]),
      .centre (raw[CENTRE_SENSOR]),
      .ctl    (ctl),
      .cfg    (cmp_cfg),
      .hit    (hits[i])
    );
  end

  // flag stage between lanes and merge
  logic                    s1_valid;
  logic                    s1_calib;
  logic [SENSOR_COUNT-1:0] s1_flags;
  logic                    merge_ready;

  assign req.ready = !s1_valid || merge_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (req.ready) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_calib <= req.req_type;
      s1_flags <= hits;
    end
  end

  lspe_merge u_merge (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (s1_valid),
    .in_ready       (merge_ready),
    .in_calib       (s1_calib),
    .in_flags       (s1_flags),
    .kp_gain        (kp_gain),
    .out_valid      (rsp.valid),
    .out_ready      (rsp.ready),
    .status_bits    (rsp.status_bits),
    .position_error (rsp.position_error),
    .drive          (rsp.drive)
  );

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> s1_valid && rsp.valid && !rsp.ready)
    else $error("request stalled with room in the pipeline");

  a_flag_stage_holds: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !req.ready |=> s1_valid && $stable(s1_flags) && $stable(s1_calib))
    else $error("flag stage lost a stalled request");

  a_gain_write: assert property (@(posedge clk) disable iff (rst)
    cfg_write && reg_idx == REG_KP_GAIN |=> kp_gain == $past(pwdata[GAIN_W-1:0]))
    else $error("gain register write lost");

endmodule

`default_nettype wire
